/* src/cmf_pkg.sv */
// ----------------------------------------------------------------------------
// Coalescing message FIFO package
// Shared message type, operation and status codes, and cell control struct.
// ----------------------------------------------------------------------------
package cmf_pkg;

	// One queued message, as stored in a cell and compared on post.
	typedef struct packed {
		logic [15:0] window;
		logic [15:0] code;
		logic [31:0] wparam;
		logic [31:0] lparam;
	} msg_t;

	// Operation codes carried by the func field.
	typedef enum logic [1:0] {
		FUNC_POST  = 2'd0,
		FUNC_GET   = 2'd1,
		FUNC_CLEAR = 2'd2
	} func_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_QUIT  = 3'd1,
		ST_EMPTY = 3'd2,
		ST_FULL  = 3'd3,
		ST_DUP   = 3'd4
	} status_t;

	// Configuration register indexes.
	localparam logic CFG_COALESCE = 1'b0;
	localparam logic CFG_QUIT     = 1'b1;

	// Configuration reset values.
	localparam logic [15:0] RST_COALESCE = 16'd2;
	localparam logic [15:0] RST_QUIT     = 16'd1;

	// Control broadcast from the top level to every cell of the chain.
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} cell_ctl_t;

endpackage

/* src/cmf_cell.sv */
// ----------------------------------------------------------------------------
// Coalescing message FIFO cell
// Holds one queue entry, shifts toward the head on pop and compares on post.
// ----------------------------------------------------------------------------
module cmf_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  cmf_pkg::cell_ctl_t ctl,
	input  cmf_pkg::msg_t      new_msg,
	input  logic               prev_valid,
	input  logic               next_valid,
	input  cmf_pkg::msg_t      next_entry,
	output logic               valid,
	output cmf_pkg::msg_t      entry,
	output logic               match
);

	logic          valid_q;
	cmf_pkg::msg_t entry_q;
	logic          load_here;

	// The first empty cell behind a full one takes a pushed word.
	assign load_here = ctl.push && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= next_valid;
		end else if (load_here) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			entry_q <= next_entry;
		end else if (load_here) begin
			entry_q <= new_msg;
		end
	end

	assign valid = valid_q;
	assign entry = entry_q;
	assign match = valid_q && (entry_q == new_msg);

endmodule

/* src/cmf_chain.sv */
// ----------------------------------------------------------------------------
// Coalescing message FIFO cell chain
// A row of cells with the oldest word in cell zero.
// ----------------------------------------------------------------------------
module cmf_chain #(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmf_pkg::cell_ctl_t ctl,
	input  cmf_pkg::msg_t      new_msg,
	output cmf_pkg::msg_t      head,
	output logic               match_any,
	output logic [DEPTH-1:0]   valid_vec
);

	logic          valid_w [DEPTH+1];
	cmf_pkg::msg_t entry_w [DEPTH+1];
	logic [DEPTH-1:0] match_vec;

	// Past the tail nothing is valid; the entry there is never loaded valid.
	assign valid_w[DEPTH] = 1'b0;
	assign entry_w[DEPTH] = new_msg;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic prev_v;
		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = valid_w[i-1];
		end

		cmf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_msg    (new_msg),
			.prev_valid (prev_v),
			.next_valid (valid_w[i+1]),
			.next_entry (entry_w[i+1]),
			.valid      (valid_w[i]),
			.entry      (entry_w[i]),
			.match      (match_vec[i])
		);

		assign valid_vec[i] = valid_w[i];
	end

	assign head      = entry_w[0];
	assign match_any = |match_vec;

endmodule

/* src/coalescing_message_fifo.sv */
// ----------------------------------------------------------------------------
// Coalescing message FIFO
// Bounded message queue with duplicate suppression for one coalescing code.
// ----------------------------------------------------------------------------
// Each input word is one operation: post a message, get the oldest message or
// clear the queue. Every operation returns exactly one result word with a
// status, the popped message (zero when nothing is popped) and the fill level
// after the operation. The word is registered in the accept cycle and is
// resolved and committed once the result register is free. The request
// register in front of the cell chain holds one word, so a new word is
// taken only after the last one has committed; the duplicate compare
// itself happens in every cell in parallel.
// ----------------------------------------------------------------------------
module coalescing_message_fifo #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,

	// Configuration write port.
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,

	// Input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [15:0] in_window,
	input  logic [15:0] in_code,
	input  logic [31:0] in_wparam,
	input  logic [31:0] in_lparam,

	// Output channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] out_window,
	output logic [15:0] out_code,
	output logic [31:0] out_wparam,
	output logic [31:0] out_lparam,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] fill_level
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	// Configuration registers.
	logic [15:0] coalesce_code_q;
	logic [15:0] quit_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coalesce_code_q <= cmf_pkg::RST_COALESCE;
			quit_code_q     <= cmf_pkg::RST_QUIT;
		end else if (cfg_write) begin
			if (cfg_index == cmf_pkg::CFG_COALESCE) begin
				coalesce_code_q <= cfg_data;
			end else begin
				quit_code_q <= cfg_data;
			end
		end
	end

	// Request register. A word sits here while the cells compare it against
	// their entries, and it stays until the result register is free.
	logic              busy_q;
	logic [1:0]        req_func_q;
	cmf_pkg::msg_t     req_msg_q;
	logic              out_valid_q;
	logic              accept;
	logic              can_commit;

	assign in_stall   = busy_q;
	assign accept     = in_valid && !in_stall;
	assign can_commit = busy_q && !(out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (can_commit) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_func_q <= func;
			req_msg_q  <= '{window: in_window, code: in_code,
			               wparam: in_wparam, lparam: in_lparam};
		end
	end

	// Cell chain. The head cell always holds the oldest queued message, so the
	// queue needs no read or write pointer, only the count.
	cmf_pkg::cell_ctl_t ctl;
	cmf_pkg::msg_t      head;
	logic               match_any;
	logic [QUEUE_DEPTH-1:0] valid_vec;

	cmf_chain #(
		.DEPTH (QUEUE_DEPTH)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.new_msg   (req_msg_q),
		.head      (head),
		.match_any (match_any),
		.valid_vec (valid_vec)
	);

	// Operation decode. The decision is made from the registered request and
	// the cell compare results, and the cells only act when it commits.
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	cmf_pkg::status_t  status_d;
	cmf_pkg::msg_t     msg_d;
	logic              push_d;
	logic              pop_d;
	logic              clear_d;

	always_comb begin
		status_d = cmf_pkg::ST_OK;
		msg_d    = '0;
		push_d   = 1'b0;
		pop_d    = 1'b0;
		clear_d  = 1'b0;
		count_d  = count_q;
		case (req_func_q)
			cmf_pkg::FUNC_POST: begin
				if (count_q == FULL_CNT) begin
					status_d = cmf_pkg::ST_FULL;
				end else if (req_msg_q.code == coalesce_code_q && match_any) begin
					status_d = cmf_pkg::ST_DUP;
				end else begin
					push_d  = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			cmf_pkg::FUNC_GET: begin
				if (count_q == '0) begin
					status_d = cmf_pkg::ST_EMPTY;
				end else begin
					pop_d   = 1'b1;
					msg_d   = head;
					count_d = count_q - CNT_W'(1);
					if (head.code == quit_code_q) begin
						status_d = cmf_pkg::ST_QUIT;
					end
				end
			end
			cmf_pkg::FUNC_CLEAR: begin
				clear_d = 1'b1;
				count_d = '0;
			end
			default: begin
				// The unused operation code leaves the queue alone.
			end
		endcase
	end

	assign ctl.push  = can_commit && push_d;
	assign ctl.pop   = can_commit && pop_d;
	assign ctl.clear = can_commit && clear_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (can_commit) begin
			count_q <= count_d;
		end
	end

	// Result register. It holds a finished word until the consumer takes it.
	cmf_pkg::status_t  status_q;
	cmf_pkg::msg_t     out_msg_q;
	logic [CNT_W-1:0]  fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (can_commit) begin
			status_q  <= status_d;
			out_msg_q <= msg_d;
			fill_q    <= count_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_window = out_msg_q.window;
	assign out_code   = out_msg_q.code;
	assign out_wparam = out_msg_q.wparam;
	assign out_lparam = out_msg_q.lparam;
	assign fill_level = fill_q;

	// The count register agrees with the number of occupied cells.
	a_count_matches_cells: assert property (
		@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q)
	) else $error("fill count differs from occupied cells");

	// Occupied cells always form one unbroken run starting at the head cell.
	a_cells_packed: assert property (
		@(posedge clk) disable iff (!arst_n)
		((valid_vec + QUEUE_DEPTH'(1)) & valid_vec) == '0
	) else $error("occupied cells are not packed toward the head");

	// Every committed operation produces a result word in the next cycle.
	a_commit_gives_result: assert property (
		@(posedge clk) disable iff (!arst_n)
		can_commit |=> out_valid_q
	) else $error("committed operation produced no result");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coalescing message FIFO testbench
// Checks every result word, against a table or a cycle-free copy of the queue.
// ----------------------------------------------------------------------------
// A short table of hand-written operations opens the run. Where the answer is
// plain (an empty queue, a fresh post, a duplicate, the spare code, a clear)
// the table holds the status and fill level itself; every other row, and all
// the random traffic after it, is checked against the in-bench queue copy.
// The random part runs in phases, each setting a pair of coalescing and quit
// codes and a mix of sender gaps and receiver stalls. Within a phase the
// traffic swings between filling and draining so that the queue reaches
// full, wraps around and runs empty again many times.
// ----------------------------------------------------------------------------
module testbench;

	localparam int DEPTH          = 32;
	localparam int PHASES         = 8;
	localparam int PHASE_WORDS    = 155;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRINT_LIMIT    = 100;
	localparam int TABLE_ROWS     = 23;

	// The func field has one code that the block does not use; it must be
	// a no-op that still returns one word.
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	localparam cmf_pkg::msg_t NIL_MSG = '0;

	// What the block should return for one operation.
	typedef struct packed {
		cmf_pkg::status_t status;
		cmf_pkg::msg_t    msg;
		logic [5:0]       fill;
	} reply_t;

	// One row of the opening table. When pinned is set, the row carries its
	// own status and fill level (with a zero message) instead of the model's.
	typedef struct packed {
		logic [1:0]       op;
		cmf_pkg::msg_t    msg;
		logic             pinned;
		cmf_pkg::status_t status;
		logic [5:0]       fill;
	} table_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [15:0] in_window;
	logic [15:0] in_code;
	logic [31:0] in_wparam;
	logic [31:0] in_lparam;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [15:0] out_window;
	logic [15:0] out_code;
	logic [31:0] out_wparam;
	logic [31:0] out_lparam;
	logic [5:0]  fill_level;

	// Software copy of the queue and of the two code registers.
	cmf_pkg::msg_t shadow_slots [DEPTH];
	int unsigned   shadow_head;
	int unsigned   shadow_count;
	logic [15:0]   shadow_coalesce;
	logic [15:0]   shadow_quit;

	// Result words still owed by the block, oldest first.
	reply_t      replies_due [$];

	int          mismatches;
	int          quiet_cycles;
	int          sender_idle_pct;
	int          receiver_stall_pct;
	int          status_tally [5];

	coalescing_message_fifo #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.in_window  (in_window),
		.in_code    (in_code),
		.in_wparam  (in_wparam),
		.in_lparam  (in_lparam),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_window (out_window),
		.out_code   (out_code),
		.out_wparam (out_wparam),
		.out_lparam (out_lparam),
		.fill_level (fill_level)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// The receiver stalls at random; the rate is set per phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("[%0t] MISMATCH %0d: %s", $realtime, mismatches, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] seen,
			input logic [31:0] wanted);
		if (seen !== wanted)
			report_mismatch($sformatf("%s is %h, expected %h", name, seen, wanted));
	endtask

	// Applies one operation to the software queue and returns the word that
	// the block must answer with. A coalescing post is compared against every
	// queued entry, and a full queue refuses the post before any comparison.
	task automatic predict_reply(input logic [1:0] op, input cmf_pkg::msg_t m,
			output reply_t r);
		logic found;
		r = '0;
		r.status = cmf_pkg::ST_OK;
		case (op)
			cmf_pkg::FUNC_POST: begin
				if (shadow_count == DEPTH) begin
					r.status = cmf_pkg::ST_FULL;
				end else begin
					found = 1'b0;
					if (m.code == shadow_coalesce)
						for (int k = 0; k < shadow_count; k++)
							if (shadow_slots[(shadow_head + k) % DEPTH] == m)
								found = 1'b1;
					if (found) begin
						r.status = cmf_pkg::ST_DUP;
					end else begin
						shadow_slots[(shadow_head + shadow_count) % DEPTH] = m;
						shadow_count++;
					end
				end
			end
			cmf_pkg::FUNC_GET: begin
				if (shadow_count == 0) begin
					r.status = cmf_pkg::ST_EMPTY;
				end else begin
					r.msg = shadow_slots[shadow_head];
					shadow_head = (shadow_head + 1) % DEPTH;
					shadow_count--;
					if (r.msg.code == shadow_quit)
						r.status = cmf_pkg::ST_QUIT;
				end
			end
			cmf_pkg::FUNC_CLEAR: begin
				shadow_count = 0;
				shadow_head = 0;
			end
			default: begin
				// The spare code leaves the queue alone.
			end
		endcase
		r.fill = shadow_count[5:0];
	endtask

	// Offers one word, holds it steady through any stall, and on acceptance
	// books the word the block owes for it.
	task automatic send_word(input logic [1:0] op, input cmf_pkg::msg_t m,
			input logic pinned, input reply_t pinned_reply);
		reply_t r;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		func      <= op;
		in_window <= m.window;
		in_code   <= m.code;
		in_wparam <= m.wparam;
		in_lparam <= m.lparam;
		do
			@(posedge clk);
		while (in_stall);
		predict_reply(op, m, r);
		if (pinned)
			r = pinned_reply;
		replies_due.push_back(r);
		status_tally[int'(r.status)]++;
	endtask

	// Stops offering words until the block has answered everything.
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	// Writes the coalescing and then the quit code register on back-to-back
	// edges. The write enable stays high across both, so it is set only once.
	task automatic program_codes(input logic [15:0] coalesce, input logic [15:0] quit);
		cfg_write <= 1'b1;
		cfg_index <= cmf_pkg::CFG_COALESCE;
		cfg_data  <= coalesce;
		@(posedge clk);
		shadow_coalesce = coalesce;
		cfg_index <= cmf_pkg::CFG_QUIT;
		cfg_data  <= quit;
		@(posedge clk);
		shadow_quit = quit;
		cfg_write <= 1'b0;
	endtask

	// Field values lean on the extremes and on a tiny range so that exact
	// duplicates come up often; the rest are fully random.
	function automatic logic [31:0] pick_value(input logic [31:0] ones);
		case ($urandom_range(3))
			0:       return '0;
			1:       return ones;
			2:       return $urandom_range(1);
			default: return $urandom & ones;
		endcase
	endfunction

	function automatic cmf_pkg::msg_t random_message();
		cmf_pkg::msg_t m;
		int            roll;
		if (shadow_count != 0 && $urandom_range(99) < 30) begin
			// Repost something already queued, often under the coalescing code.
			m = shadow_slots[(shadow_head + $urandom_range(shadow_count - 1)) % DEPTH];
			if ($urandom_range(1) == 0)
				m.code = shadow_coalesce;
			return m;
		end
		m.window = 16'(pick_value(32'h0000_ffff));
		roll = $urandom_range(99);
		if (roll < 45)
			m.code = shadow_coalesce;
		else if (roll < 60)
			m.code = shadow_quit;
		else
			m.code = 16'(pick_value(32'h0000_ffff));
		m.wparam = pick_value(32'hffff_ffff);
		m.lparam = pick_value(32'hffff_ffff);
		return m;
	endfunction

	// Result checking and the watchdog. Both read the handshake signals as
	// they stood before this edge.
	always @(posedge clk) begin
		reply_t want;
		logic   moved;
		if (arst_n) begin
			moved = 1'b0;
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (replies_due.size() == 0) begin
					report_mismatch($sformatf("result word with nothing pending, status %0d",
						status));
				end else begin
					want = replies_due.pop_front();
					check_field("status", 32'(status), 32'(want.status));
					check_field("out_window", 32'(out_window), 32'(want.msg.window));
					check_field("out_code", 32'(out_code), 32'(want.msg.code));
					check_field("out_wparam", out_wparam, want.msg.wparam);
					check_field("out_lparam", out_lparam, want.msg.lparam);
					check_field("fill_level", 32'(fill_level), 32'(want.fill));
				end
			end
			if (in_valid && !in_stall)
				moved = 1'b1;
			if (moved)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: no word moved for %0d cycles, %0d results pending",
					$realtime, WATCHDOG_LIMIT, replies_due.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		table_row_t    opening [TABLE_ROWS];
		logic [15:0]   coalesce_codes [PHASES];
		logic [15:0]   quit_codes [PHASES];
		int            idle_mix [4];
		int            stall_mix [4];
		logic [1:0]    op;
		cmf_pkg::msg_t m;
		logic          filling;
		int            roll;
		int            sent;
		int            total_words;

		arst_n    <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= cmf_pkg::CFG_COALESCE;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		func      <= cmf_pkg::FUNC_POST;
		in_window <= '0;
		in_code   <= '0;
		in_wparam <= '0;
		in_lparam <= '0;
		out_stall <= 1'b0;

		shadow_head        = 0;
		shadow_count       = 0;
		shadow_coalesce    = cmf_pkg::RST_COALESCE;
		shadow_quit        = cmf_pkg::RST_QUIT;
		mismatches         = 0;
		quiet_cycles       = 0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		total_words        = 0;
		foreach (status_tally[i])
			status_tally[i] = 0;

		// The opening table runs under the reset codes: coalescing code 2 and
		// quit code 1. It covers get on empty, the spare code, a coalesced
		// duplicate, near-misses that differ in one field, a repeated message
		// under a non-coalescing code, a quit pop, and clear with a queue left
		// half used so that storage restarts from the first slot.
		opening = '{
			'{cmf_pkg::FUNC_GET,   NIL_MSG, 1'b1, cmf_pkg::ST_EMPTY, 6'd0},
			'{FUNC_SPARE,          NIL_MSG, 1'b1, cmf_pkg::ST_OK, 6'd0},
			'{cmf_pkg::FUNC_POST,  '{16'hffff, 16'h0002, 32'hffff_ffff, 32'hffff_ffff},
				1'b1, cmf_pkg::ST_OK, 6'd1},
			'{cmf_pkg::FUNC_POST,  '{16'hffff, 16'h0002, 32'hffff_ffff, 32'hffff_ffff},
				1'b1, cmf_pkg::ST_DUP, 6'd1},
			'{cmf_pkg::FUNC_POST,  '{16'h0000, 16'h0001, 32'h0, 32'h0},
				1'b1, cmf_pkg::ST_OK, 6'd2},
			'{cmf_pkg::FUNC_POST,  '{16'hffff, 16'h0002, 32'hffff_ffff, 32'hffff_fffe},
				1'b1, cmf_pkg::ST_OK, 6'd3},
			'{cmf_pkg::FUNC_POST,  '{16'h0000, 16'h0001, 32'h0, 32'h0},
				1'b1, cmf_pkg::ST_OK, 6'd4},
			'{cmf_pkg::FUNC_POST,  '{16'hfffe, 16'h0002, 32'hffff_ffff, 32'hffff_ffff},
				1'b1, cmf_pkg::ST_OK, 6'd5},
			'{cmf_pkg::FUNC_POST,  '{16'hffff, 16'h0002, 32'h7fff_ffff, 32'hffff_ffff},
				1'b1, cmf_pkg::ST_OK, 6'd6},
			'{cmf_pkg::FUNC_POST,  '{16'hffff, 16'h0003, 32'hffff_ffff, 32'hffff_ffff},
				1'b1, cmf_pkg::ST_OK, 6'd7},
			'{FUNC_SPARE,          '{16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff},
				1'b1, cmf_pkg::ST_OK, 6'd7},
			'{cmf_pkg::FUNC_GET,   NIL_MSG, 1'b0, cmf_pkg::ST_OK, 6'd0},
			'{cmf_pkg::FUNC_GET,   NIL_MSG, 1'b0, cmf_pkg::ST_OK, 6'd0},
			'{cmf_pkg::FUNC_POST,  '{16'hffff, 16'h0002, 32'hffff_ffff, 32'hffff_ffff},
				1'b0, cmf_pkg::ST_OK, 6'd0},
			'{cmf_pkg::FUNC_POST,  '{16'hffff, 16'h0002, 32'hffff_ffff, 32'hffff_fffe},
				1'b0, cmf_pkg::ST_OK, 6'd0},
			'{cmf_pkg::FUNC_GET,   NIL_MSG, 1'b0, cmf_pkg::ST_OK, 6'd0},
			'{cmf_pkg::FUNC_CLEAR, '{16'h1234, 16'h0002, 32'hdead_beef, 32'h0000_0001},
				1'b1, cmf_pkg::ST_OK, 6'd0},
			'{cmf_pkg::FUNC_GET,   NIL_MSG, 1'b1, cmf_pkg::ST_EMPTY, 6'd0},
			'{cmf_pkg::FUNC_POST,  NIL_MSG, 1'b1, cmf_pkg::ST_OK, 6'd1},
			'{cmf_pkg::FUNC_POST,  NIL_MSG, 1'b1, cmf_pkg::ST_OK, 6'd2},
			'{cmf_pkg::FUNC_GET,   NIL_MSG, 1'b0, cmf_pkg::ST_OK, 6'd0},
			'{cmf_pkg::FUNC_GET,   NIL_MSG, 1'b0, cmf_pkg::ST_OK, 6'd0},
			'{cmf_pkg::FUNC_GET,   NIL_MSG, 1'b1, cmf_pkg::ST_EMPTY, 6'd0}
		};

		// Code pairs per phase: the reset pair, both extremes each way, the
		// same code for both roles, and random picks.
		coalesce_codes = '{16'd2, 16'h0000, 16'hffff, 16'hffff, 16'h0000,
			16'(($urandom)), 16'h0000, 16'd2};
		quit_codes     = '{16'd1, 16'hffff, 16'h0000, 16'hffff, 16'h0000,
			16'(($urandom)), 16'h0000, 16'd1};
		quit_codes[6]     = 16'($urandom);
		coalesce_codes[6] = quit_codes[6];

		// Idling mixes, taken in turn: none, a sluggish sender, a sluggish
		// receiver, and light idling on both sides.
		idle_mix  = '{0, 73, 0, 17};
		stall_mix = '{0, 0, 73, 17};

		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) begin
			send_word(opening[i].op, opening[i].msg, opening[i].pinned,
				'{opening[i].status, NIL_MSG, opening[i].fill});
			total_words++;
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			// Codes change only while nothing is in flight.
			wait_until_drained();
			program_codes(coalesce_codes[phase], quit_codes[phase]);
			sender_idle_pct    = idle_mix[phase % 4];
			receiver_stall_pct = stall_mix[phase % 4];
			filling = 1'b1;
			sent = 0;
			while (sent < PHASE_WORDS) begin
				// Swing between filling and draining, lingering at full and at
				// empty long enough to see refused posts and empty gets.
				if (filling && shadow_count == DEPTH && $urandom_range(5) == 0)
					filling = 1'b0;
				else if (!filling && shadow_count == 0 && $urandom_range(2) == 0)
					filling = 1'b1;
				else if ($urandom_range(49) == 0)
					filling = !filling;

				roll = $urandom_range(99);
				if (filling)
					op = (roll < 88) ? cmf_pkg::FUNC_POST :
						(roll < 96) ? cmf_pkg::FUNC_GET :
						(roll < 97) ? cmf_pkg::FUNC_CLEAR : FUNC_SPARE;
				else
					op = (roll < 78) ? cmf_pkg::FUNC_GET :
						(roll < 94) ? cmf_pkg::FUNC_POST :
						(roll < 97) ? cmf_pkg::FUNC_CLEAR : FUNC_SPARE;
				m = random_message();

				// Now and then the sender holds off until the queue of
				// answers is empty, so that the block restarts from idle.
				if ($urandom_range(199) == 0)
					wait_until_drained();

				send_word(op, m, 1'b0, '0);
				total_words++;
				if (op != FUNC_SPARE)
					sent++;
			end
		end

		in_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		// Waiting on after the drain catches any stray extra result word.
		repeat (10)
			@(posedge clk);

		$display("Covered %0d words over %0d code settings: %0d ok, %0d quit pops,",
			total_words, PHASES + 1, status_tally[cmf_pkg::ST_OK],
			status_tally[cmf_pkg::ST_QUIT]);
		$display("%0d empty gets, %0d full refusals, %0d coalesced drops; %0d mismatches.",
			status_tally[cmf_pkg::ST_EMPTY], status_tally[cmf_pkg::ST_FULL],
			status_tally[cmf_pkg::ST_DUP], mismatches);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* coalescing_message_fifo.f */
src/cmf_pkg.sv
src/cmf_cell.sv
src/cmf_chain.sv
src/coalescing_message_fifo.sv
tb/testbench.sv
